[rtl/tslx_pkg.sv]
// ----------------------------------------------------------------------------
// Token lexer package
// Token and queue entry types, token kind codes and keyword helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package tslx_pkg;

    localparam logic [3:0] KIND_IDENT    = 4'd0;
    localparam logic [3:0] KIND_KEYWORD  = 4'd1;
    localparam logic [3:0] KIND_CONSTANT = 4'd2;
    localparam logic [3:0] KIND_LPAREN   = 4'd3;
    localparam logic [3:0] KIND_RPAREN   = 4'd4;
    localparam logic [3:0] KIND_LBRACE   = 4'd5;
    localparam logic [3:0] KIND_RBRACE   = 4'd6;
    localparam logic [3:0] KIND_SEMI     = 4'd7;
    localparam logic [3:0] KIND_UNKNOWN  = 4'd8;
    localparam logic [3:0] KIND_END      = 4'd9;

    localparam logic [1:0] KW_INT    = 2'd0;
    localparam logic [1:0] KW_RETURN = 2'd1;
    localparam logic [1:0] KW_VOID   = 2'd2;

    localparam logic [2:0] ALL_CANDIDATES = 3'b111;

    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  kw_index;
        logic [31:0] start;
        logic [7:0]  length;
        logic        too_long;
    } t_token;

    typedef struct packed {
        logic   v0;
        t_token t0;
        logic   v1;
        t_token t1;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] len;
        unique case (k)
            KW_INT:    len = 3'd3;
            KW_RETURN: len = 3'd6;
            KW_VOID:   len = 3'd4;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (k)
            KW_INT: begin
                unique case (idx)
                    3'd0:    ch = 8'h69;
                    3'd1:    ch = 8'h6E;
                    3'd2:    ch = 8'h74;
                    default: ch = 8'h00;
                endcase
            end
            KW_RETURN: begin
                unique case (idx)
                    3'd0:    ch = 8'h72;
                    3'd1:    ch = 8'h65;
                    3'd2:    ch = 8'h74;
                    3'd3:    ch = 8'h75;
                    3'd4:    ch = 8'h72;
                    3'd5:    ch = 8'h6E;
                    default: ch = 8'h00;
                endcase
            end
            KW_VOID: begin
                unique case (idx)
                    3'd0:    ch = 8'h76;
                    3'd1:    ch = 8'h6F;
                    3'd2:    ch = 8'h69;
                    3'd3:    ch = 8'h64;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Keeps the keywords that still match the word once byte c sits at position idx.
    function automatic logic [2:0] narrow(input logic [2:0] live, input logic [2:0] idx,
                                          input logic idx_ok, input logic [7:0] c);
        logic [2:0] res;
        res = 3'b000;
        for (int k = 0; k < 3; k++) begin
            if (live[k] && idx_ok && idx < kw_len(2'(k)) && kw_char(2'(k), idx) == c) begin
                res[k] = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/tslx_front.sv]
// ----------------------------------------------------------------------------
// Token lexer front end, tracking the pending token
// Accepts one byte per cycle while the queue has room; builds queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

module tslx_front #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int OFFSET_WIDTH  = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_char,
    input  wire logic            i_end,
    input  wire tslx_pkg::t_q_stat i_q_stat,
    output logic                 o_push,
    output tslx_pkg::t_entry     o_entry
);

    localparam int CW = $clog2(MAX_TOKEN_LEN + 1);

    typedef enum logic [1:0] {MODE_IDLE, MODE_WORD, MODE_NUM} t_mode;

    t_mode                   r_mode, n_mode;
    logic [OFFSET_WIDTH-1:0] r_start, n_start;
    logic [OFFSET_WIDTH-1:0] r_pos, n_pos;
    logic [CW-1:0]           r_count, n_count;
    logic [2:0]              r_cands, n_cands;

    logic        accept;
    logic        is_dig, word_start, word_char, extend;
    logic        kw_hit;
    logic [1:0]  kw_idx;
    logic [16:0] count_x;
    logic [31:0] pos32;
    logic        idx_ok;

    tslx_pkg::t_token tok0, tok1;
    logic             v0, v1;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    assign is_dig     = tslx_pkg::is_digit(i_char);
    assign word_start = tslx_pkg::is_alpha(i_char) || i_char == tslx_pkg::CH_UNDERSCORE;
    assign word_char  = word_start || is_dig;
    assign extend     = !i_end && ((r_mode == MODE_WORD && word_char) ||
                                   (r_mode == MODE_NUM && is_dig));
    assign count_x    = 17'(r_count);
    assign pos32      = 32'(r_pos);
    assign idx_ok     = (r_count >> 3) == '0;

    always_comb begin
        kw_hit = 1'b0;
        kw_idx = tslx_pkg::KW_INT;
        for (int k = 2; k >= 0; k--) begin
            if (r_cands[k] && r_count == CW'(tslx_pkg::kw_len(2'(k)))) begin
                kw_hit = 1'b1;
                kw_idx = 2'(k);
            end
        end
    end

    always_comb begin
        v0 = !extend && r_mode != MODE_IDLE;
        tok0.kind     = (r_mode == MODE_NUM) ? tslx_pkg::KIND_CONSTANT :
                        (kw_hit ? tslx_pkg::KIND_KEYWORD : tslx_pkg::KIND_IDENT);
        tok0.kw_index = (r_mode == MODE_WORD && kw_hit) ? kw_idx : tslx_pkg::KW_INT;
        tok0.start    = 32'(r_start);
        tok0.length   = (count_x > 17'd255) ? 8'hFF : count_x[7:0];
        tok0.too_long = r_count >= CW'(MAX_TOKEN_LEN);

        v1 = 1'b0;
        tok1.kind     = tslx_pkg::KIND_UNKNOWN;
        tok1.kw_index = tslx_pkg::KW_INT;
        tok1.start    = pos32;
        tok1.length   = 8'd1;
        tok1.too_long = 1'b0;
        if (i_end) begin
            v1          = 1'b1;
            tok1.kind   = tslx_pkg::KIND_END;
            tok1.length = 8'd0;
        end else if (!extend && !word_char && !tslx_pkg::is_space(i_char)) begin
            v1 = 1'b1;
            unique case (i_char)
                tslx_pkg::CH_LPAREN: tok1.kind = tslx_pkg::KIND_LPAREN;
                tslx_pkg::CH_RPAREN: tok1.kind = tslx_pkg::KIND_RPAREN;
                tslx_pkg::CH_LBRACE: tok1.kind = tslx_pkg::KIND_LBRACE;
                tslx_pkg::CH_RBRACE: tok1.kind = tslx_pkg::KIND_RBRACE;
                tslx_pkg::CH_SEMI:   tok1.kind = tslx_pkg::KIND_SEMI;
                default:             tok1.kind = tslx_pkg::KIND_UNKNOWN;
            endcase
        end
    end

    assign o_push  = accept && (v0 || v1);
    assign o_entry = '{v0: v0, t0: tok0, v1: v1, t1: tok1};

    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_pos   = r_pos;
        n_count = r_count;
        n_cands = r_cands;
        if (i_end) begin
            n_mode  = MODE_IDLE;
            n_count = '0;
            n_cands = tslx_pkg::ALL_CANDIDATES;
            n_pos   = '0;
            n_start = '0;
        end else begin
            n_pos = r_pos + 1'b1;
            if (extend) begin
                n_cands = tslx_pkg::narrow(r_cands, r_count[2:0], idx_ok, i_char);
                if (r_count < CW'(MAX_TOKEN_LEN)) begin
                    n_count = r_count + 1'b1;
                end
            end else if (word_char) begin
                n_mode  = word_start ? MODE_WORD : MODE_NUM;
                n_start = r_pos;
                n_count = CW'(1);
                n_cands = tslx_pkg::narrow(tslx_pkg::ALL_CANDIDATES, 3'd0, 1'b1, i_char);
            end else begin
                n_mode  = MODE_IDLE;
                n_count = '0;
                n_cands = tslx_pkg::ALL_CANDIDATES;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_pos   <= '0;
            r_count <= '0;
            r_cands <= tslx_pkg::ALL_CANDIDATES;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_count <= n_count;
            r_cands <= n_cands;
        end
    end

endmodule

`default_nettype wire

[rtl/tslx_queue.sv]
// ----------------------------------------------------------------------------
// Token lexer queue
// Short first-in first-out buffer of token pairs between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tslx_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire tslx_pkg::t_entry  i_entry,
    input  wire logic              i_pop,
    output tslx_pkg::t_entry       o_head,
    output tslx_pkg::t_q_stat      o_stat
);

    tslx_pkg::t_entry            r_mem [tslx_pkg::QUEUE_DEPTH];
    logic [tslx_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [tslx_pkg::QPTR_W:0]   r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = r_cnt == (tslx_pkg::QPTR_W + 1)'(tslx_pkg::QUEUE_DEPTH);
    assign o_stat.empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/tslx_back.sv]
// ----------------------------------------------------------------------------
// Token lexer back end
// Splits queued token pairs into single words and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tslx_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tslx_pkg::t_entry  i_head,
    input  wire tslx_pkg::t_q_stat i_q_stat,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output tslx_pkg::t_token       o_token,
    output logic                   o_last
);

    logic             r_valid, r_last, r_sel;
    tslx_pkg::t_token r_token;

    logic             load, use_first, pick_last;
    tslx_pkg::t_token pick;

    assign load      = (!r_valid || i_ready) && !i_q_stat.empty;
    assign use_first = !r_sel && i_head.v0;
    assign pick      = use_first ? i_head.t0 : i_head.t1;
    assign pick_last = use_first ? !i_head.v1 : 1'b1;
    assign o_pop     = load && pick_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_last  <= pick_last;
                r_sel   <= !pick_last;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_token <= pick;
        end
    end

    assign o_valid = r_valid;
    assign o_token = r_token;
    assign o_last  = r_last;

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_token.kind == tslx_pkg::KIND_END) |-> r_last)
        else $error("End word without last flag.");

    a_end_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_token.kind == tslx_pkg::KIND_END) |-> r_token.length == 8'd0)
        else $error("End word with nonzero length.");

    a_second_half_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> !i_q_stat.empty)
        else $error("Second word of a pair selected with an empty queue.");

endmodule

`default_nettype wire

[rtl/c_subset_token_lexer_unit.sv]
// ----------------------------------------------------------------------------
// Streaming lexer for a small subset of C
// Turns a byte stream into identifier, keyword, constant and symbol tokens.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle on the slave side, with tlast
// marking end of text (tdata is ignored on that word), and returns tokens on
// the master side. A byte is taken every cycle while the four-entry token
// queue between front and back end has room; each byte yields zero, one or
// two tokens, and the output register sends one token per cycle while tready
// is high, so the sustained rate is one byte per cycle unless the text holds
// many word-then-symbol pairs, where the single output port sets the pace.
// A byte's tokens pass through the queue into the output register. tlast on
// the master side marks the final token caused by one input word.
`default_nettype none

module c_subset_token_lexer_unit #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int OFFSET_WIDTH  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  wire logic        i_s_tlast,   // end_of_text
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,   // [1:0] keyword_index, [33:2] start_offset,
                                          // [41:34] token_length, [42] too_long
    output logic [3:0]       o_m_tuser,   // [3:0] token_kind
    output logic             o_m_tlast    // last_of_run
);

    tslx_pkg::t_q_stat q_stat;
    tslx_pkg::t_entry  push_entry, head;
    tslx_pkg::t_token  out_token;
    logic              push, pop;

    tslx_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .OFFSET_WIDTH  (OFFSET_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_char   (i_s_tdata),
        .i_end    (i_s_tlast),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    tslx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    tslx_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_token  (out_token),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = {5'b00000, out_token.too_long, out_token.length,
                        out_token.start, out_token.kw_index};
    assign o_m_tuser = out_token.kind;

endmodule

`default_nettype wire

[tb/c_subset_token_lexer_unit_test.sv]
// ----------------------------------------------------------------------------
// Token lexer unit testbench
// Streams source bytes into the lexer and checks every token against a
// behavioral predictor: a short directed table first, then C-like random text
// under three idle patterns, one of them with a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module c_subset_token_lexer_unit_test;

    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  kw;
        logic [31:0] start;
        logic [7:0]  len;
        logic        too_long;
        logic        last;
    } t_lex_token;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER} t_scan;

    typedef struct {
        logic [7:0] ch;
        string      txt;
        int         reps;
        bit         eot;
        bit         typed;
        t_lex_token tok;
    } t_stim_row;

    localparam int MAX_LEN = 255;
    localparam int N_ROWS = 23;
    localparam t_lex_token NO_TOKEN = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;
    logic [3:0]  o_m_tuser;
    logic        o_m_tlast;

    c_subset_token_lexer_unit #(
        .MAX_TOKEN_LEN(MAX_LEN),
        .OFFSET_WIDTH(32)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),      // [7:0] char_code
        .i_s_tlast(i_s_tlast),      // end_of_text
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),      // [1:0] keyword_index, [33:2] start_offset,
                                    // [41:34] token_length, [42] too_long
        .o_m_tuser(o_m_tuser),      // [3:0] token_kind
        .o_m_tlast(o_m_tlast)       // last_of_run
    );

    always #5 i_clk = ~i_clk;

    string kw_word [3] = '{"int", "return", "void"};
    string near_kw [12] = '{"int", "return", "void", "in", "inta", "retur", "returns",
                            "voi", "voidx", "i", "r", "v"};
    string sym_chars = "(){};";
    string ws_chars = " \t\n\v\f\015";

    t_stim_row dir_rows [N_ROWS] = '{
        '{tslx_pkg::CH_LPAREN, "", 1, 1'b0, 1'b1,
          '{tslx_pkg::KIND_LPAREN, tslx_pkg::KW_INT, 32'd0, 8'd1, 1'b0, 1'b1}},
        '{tslx_pkg::CH_RPAREN, "", 1, 1'b0, 1'b1,
          '{tslx_pkg::KIND_RPAREN, tslx_pkg::KW_INT, 32'd1, 8'd1, 1'b0, 1'b1}},
        '{tslx_pkg::CH_LBRACE, "", 1, 1'b0, 1'b1,
          '{tslx_pkg::KIND_LBRACE, tslx_pkg::KW_INT, 32'd2, 8'd1, 1'b0, 1'b1}},
        '{tslx_pkg::CH_RBRACE, "", 1, 1'b0, 1'b1,
          '{tslx_pkg::KIND_RBRACE, tslx_pkg::KW_INT, 32'd3, 8'd1, 1'b0, 1'b1}},
        '{tslx_pkg::CH_SEMI,   "", 1, 1'b0, 1'b1,
          '{tslx_pkg::KIND_SEMI, tslx_pkg::KW_INT, 32'd4, 8'd1, 1'b0, 1'b1}},
        '{8'h00, "", 1, 1'b0, 1'b1,
          '{tslx_pkg::KIND_UNKNOWN, tslx_pkg::KW_INT, 32'd5, 8'd1, 1'b0, 1'b1}},
        '{8'hFF, "", 1, 1'b0, 1'b1,
          '{tslx_pkg::KIND_UNKNOWN, tslx_pkg::KW_INT, 32'd6, 8'd1, 1'b0, 1'b1}},
        '{8'h80, "", 1, 1'b0, 1'b1,
          '{tslx_pkg::KIND_UNKNOWN, tslx_pkg::KW_INT, 32'd7, 8'd1, 1'b0, 1'b1}},
        '{8'h08, "", 1, 1'b0, 1'b1,
          '{tslx_pkg::KIND_UNKNOWN, tslx_pkg::KW_INT, 32'd8, 8'd1, 1'b0, 1'b1}},
        '{8'h0E, "", 1, 1'b0, 1'b1,
          '{tslx_pkg::KIND_UNKNOWN, tslx_pkg::KW_INT, 32'd9, 8'd1, 1'b0, 1'b1}},
        '{8'h00, "\t\n\v\f\015 ", 1, 1'b0, 1'b0, NO_TOKEN},
        '{8'h00, "int return void ", 1, 1'b0, 1'b0, NO_TOKEN},
        '{8'h00, "in inta retur returnx voi vo_d _x9Z q ", 1, 1'b0, 1'b0, NO_TOKEN},
        '{8'h00, "12ab 7;x(", 1, 1'b0, 1'b0, NO_TOKEN},
        '{8'h00, "int", 1, 1'b1, 1'b0, NO_TOKEN},
        '{8'h00, "", 0, 1'b1, 1'b1,
          '{tslx_pkg::KIND_END, tslx_pkg::KW_INT, 32'd0, 8'd0, 1'b0, 1'b1}},
        '{8'h00, "a", 254, 1'b0, 1'b0, NO_TOKEN},
        '{tslx_pkg::CH_RPAREN, "", 1, 1'b0, 1'b0, NO_TOKEN},
        '{8'h00, "b", 255, 1'b0, 1'b0, NO_TOKEN},
        '{tslx_pkg::CH_SPACE, "", 1, 1'b0, 1'b0, NO_TOKEN},
        '{8'h00, "c", 300, 1'b1, 1'b0, NO_TOKEN},
        '{8'h00, "9", 256, 1'b1, 1'b0, NO_TOKEN},
        '{8'h00, "void", 1, 1'b1, 1'b0, NO_TOKEN}
    };

    // Lexer state as the predictor sees it.
    t_scan       lx_mode = SCAN_IDLE;
    logic [31:0] lx_start = '0;
    int          lx_len = 0;
    logic [2:0]  lx_live = tslx_pkg::ALL_CANDIDATES;
    logic [31:0] lx_pos = '0;

    t_lex_token  step_tok [2];
    int          step_cnt;
    t_lex_token  expected_tokens [$];

    int send_idle = 0;
    int recv_idle = 0;
    bit pressure_on = 1'b0;
    logic hold_active = 1'b0;

    int errors = 0;
    int words_sent = 0;
    int tokens_checked = 0;
    int long_seen = 0;
    int kinds_hit [10];
    t_lex_token got_tok;
    t_lex_token want_tok;

    function automatic void queue_token(t_lex_token tok);
        expected_tokens.insert(expected_tokens.size(), tok);
    endfunction

    function automatic logic [2:0] keep_keywords(logic [2:0] live, int idx, logic [7:0] c);
        logic [2:0] res;
        res = '0;
        for (int k = 0; k < 3; k++) begin
            if (live[k] && idx < kw_word[k].len() && kw_word[k][idx] == c) begin
                res[k] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic void push_token(logic [3:0] kind, logic [1:0] kw, logic [31:0] start,
                                       int len);
        step_tok[step_cnt] = '{kind, kw, start, 8'(len), len >= MAX_LEN, 1'b0};
        step_cnt++;
    endfunction

    function automatic void close_token();
        logic [3:0] kind;
        logic [1:0] kw;
        bit         found;
        if (lx_mode == SCAN_WORD) begin
            kind = tslx_pkg::KIND_IDENT;
            kw = tslx_pkg::KW_INT;
            found = 1'b0;
            for (int k = 0; k < 3; k++) begin
                if (!found && lx_live[k] && lx_len == kw_word[k].len()) begin
                    kind = tslx_pkg::KIND_KEYWORD;
                    kw = 2'(k);
                    found = 1'b1;
                end
            end
            push_token(kind, kw, lx_start, lx_len);
        end else if (lx_mode == SCAN_NUMBER) begin
            push_token(tslx_pkg::KIND_CONSTANT, tslx_pkg::KW_INT, lx_start, lx_len);
        end
        lx_mode = SCAN_IDLE;
        lx_len = 0;
        lx_live = tslx_pkg::ALL_CANDIDATES;
    endfunction

    function automatic void lex_predict(logic [7:0] c, logic eot);
        logic letter;
        logic digit;
        logic under;
        step_cnt = 0;
        letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        digit = c >= "0" && c <= "9";
        under = c == tslx_pkg::CH_UNDERSCORE;
        if (eot) begin
            close_token();
            push_token(tslx_pkg::KIND_END, tslx_pkg::KW_INT, lx_pos, 0);
            lx_pos = '0;
            lx_start = '0;
        end else begin
            if ((lx_mode == SCAN_WORD && (letter || digit || under)) ||
                (lx_mode == SCAN_NUMBER && digit)) begin
                lx_live = keep_keywords(lx_live, lx_len, c);
                if (lx_len < MAX_LEN) begin
                    lx_len++;
                end
            end else begin
                close_token();
                if (letter || under || digit) begin
                    lx_mode = digit ? SCAN_NUMBER : SCAN_WORD;
                    lx_start = lx_pos;
                    lx_len = 1;
                    lx_live = keep_keywords(tslx_pkg::ALL_CANDIDATES, 0, c);
                end else begin
                    unique case (c)
                        tslx_pkg::CH_LPAREN:
                            push_token(tslx_pkg::KIND_LPAREN, tslx_pkg::KW_INT, lx_pos, 1);
                        tslx_pkg::CH_RPAREN:
                            push_token(tslx_pkg::KIND_RPAREN, tslx_pkg::KW_INT, lx_pos, 1);
                        tslx_pkg::CH_LBRACE:
                            push_token(tslx_pkg::KIND_LBRACE, tslx_pkg::KW_INT, lx_pos, 1);
                        tslx_pkg::CH_RBRACE:
                            push_token(tslx_pkg::KIND_RBRACE, tslx_pkg::KW_INT, lx_pos, 1);
                        tslx_pkg::CH_SEMI:
                            push_token(tslx_pkg::KIND_SEMI, tslx_pkg::KW_INT, lx_pos, 1);
                        default: begin
                            if (!(c == tslx_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13))) begin
                                push_token(tslx_pkg::KIND_UNKNOWN, tslx_pkg::KW_INT,
                                           lx_pos, 1);
                            end
                        end
                    endcase
                end
            end
            lx_pos = lx_pos + 32'd1;
        end
        if (step_cnt > 0) begin
            step_tok[step_cnt - 1].last = 1'b1;
        end
    endfunction

    task automatic send_word(logic [7:0] c, logic eot, bit typed, t_lex_token tok);
        while ($urandom_range(0, 99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= eot ? 8'($urandom) : c;
        i_s_tlast <= eot;
        do @(posedge i_clk); while (!o_s_tready);
        lex_predict(c, eot);
        if (typed) begin
            queue_token(tok);
        end else begin
            for (int i = 0; i < step_cnt; i++) begin
                queue_token(step_tok[i]);
            end
        end
        words_sent++;
    endtask

    task automatic send_text(string s, int reps);
        repeat (reps) begin
            for (int i = 0; i < s.len(); i++) begin
                send_word(s[i], 1'b0, 1'b0, NO_TOKEN);
            end
        end
    endtask

    function automatic logic [7:0] word_char(bit allow_digit);
        int r;
        r = $urandom_range(0, allow_digit ? 62 : 52);
        if (r < 26) begin
            return 8'("a" + r);
        end else if (r < 52) begin
            return 8'("A" + r - 26);
        end else if (r == 52) begin
            return tslx_pkg::CH_UNDERSCORE;
        end
        return 8'("0" + r - 53);
    endfunction

    task automatic random_piece();
        int sel;
        int n;
        sel = $urandom_range(0, 999);
        if (sel < 300) begin
            n = (sel < 3) ? $urandom_range(250, 262) : $urandom_range(1, 8);
            send_word(word_char(1'b0), 1'b0, 1'b0, NO_TOKEN);
            repeat (n - 1) send_word(word_char(1'b1), 1'b0, 1'b0, NO_TOKEN);
        end else if (sel < 420) begin
            send_text(near_kw[$urandom_range(0, 11)], 1);
        end else if (sel < 540) begin
            repeat ($urandom_range(1, 6)) begin
                send_word(8'("0" + $urandom_range(0, 9)), 1'b0, 1'b0, NO_TOKEN);
            end
        end else if (sel < 750) begin
            send_word(sym_chars[$urandom_range(0, 4)], 1'b0, 1'b0, NO_TOKEN);
        end else if (sel < 880) begin
            send_word(ws_chars[$urandom_range(0, 5)], 1'b0, 1'b0, NO_TOKEN);
        end else if (sel < 975) begin
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_TOKEN);
        end else begin
            send_word(8'($urandom), 1'b1, 1'b0, NO_TOKEN);
        end
    endtask

    task automatic run_random(int count, int s_idle, int r_idle);
        int target;
        send_idle = s_idle;
        recv_idle = r_idle;
        target = words_sent + count;
        while (words_sent < target) begin
            random_piece();
        end
    endtask

    always @(posedge i_clk) begin
        i_m_tready <= !hold_active && ($urandom_range(0, 99) >= recv_idle);
    end

    initial begin
        wait (pressure_on);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_tok = '{o_m_tuser, o_m_tdata[1:0], o_m_tdata[33:2], o_m_tdata[41:34],
                        o_m_tdata[42], o_m_tlast};
            if (expected_tokens.size() == 0) begin
                errors++;
                $display("%0t: unexpected token kind %0d start %0d len %0d", $time,
                         got_tok.kind, got_tok.start, got_tok.len);
            end else begin
                want_tok = expected_tokens.pop_front();
                if (got_tok !== want_tok || o_m_tdata[47:43] !== 5'b0) begin
                    errors++;
                    $display("%0t: expected kind %0d kw %0d start %0d len %0d long %0b last %0b",
                             $time, want_tok.kind, want_tok.kw, want_tok.start, want_tok.len,
                             want_tok.too_long, want_tok.last);
                    $display("%0t: actual kind %0d kw %0d start %0d len %0d long %0b last %0b",
                             $time, got_tok.kind, got_tok.kw, got_tok.start, got_tok.len,
                             got_tok.too_long, got_tok.last);
                    $display("%0t: actual pad %0h", $time, o_m_tdata[47:43]);
                end
            end
            tokens_checked++;
            if (got_tok.kind < 10) begin
                kinds_hit[got_tok.kind]++;
            end
            if (got_tok.too_long) begin
                long_seen++;
            end
        end
    end

    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int kinds;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 36;
        recv_idle = 79;
        for (int r = 0; r < N_ROWS; r++) begin
            if (dir_rows[r].txt.len() == 0) begin
                repeat (dir_rows[r].reps) begin
                    send_word(dir_rows[r].ch, 1'b0, dir_rows[r].typed, dir_rows[r].tok);
                end
            end else begin
                send_text(dir_rows[r].txt, dir_rows[r].reps);
            end
            if (dir_rows[r].eot) begin
                send_word(8'h00, 1'b1, dir_rows[r].typed, dir_rows[r].tok);
            end
        end
        run_random(60, 36, 79);
        run_random(50, 79, 36);
        pressure_on = 1'b1;
        run_random(40, 0, 0);
        send_word(8'h00, 1'b1, 1'b0, NO_TOKEN);
        i_s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        kinds = 0;
        for (int k = 0; k < 10; k++) begin
            if (kinds_hit[k] != 0) begin
                kinds++;
            end
        end
        $display("Sent %0d source words and checked %0d tokens.", words_sent, tokens_checked);
        $display("Token kinds seen: %0d of 10; saturated long tokens: %0d.", kinds, long_seen);
        if (errors == 0 && expected_tokens.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
